@@ design/u16u8_pkg.sv @@
// Shared types and constants for the UTF-16LE to UTF-8 budgeted transcoder.
`default_nettype none

package u16u8_pkg;

    // Width of the unit and byte counters; summaries show their low 16 bits
    localparam int COUNT_WIDTH = 16;

    // Stop status codes
    localparam logic [1:0] STOP_NONE = 2'd0;
    localparam logic [1:0] STOP_FULL = 2'd1;
    localparam logic [1:0] STOP_SURR = 2'd2;

    // Result kinds
    localparam logic KIND_BYTE    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // UTF-8 byte prefixes
    localparam logic [2:0] LEAD2_PREFIX = 3'b110;
    localparam logic [3:0] LEAD3_PREFIX = 4'b1110;
    localparam logic [1:0] CONT_PREFIX  = 2'b10;

    // High surrogate range 0xD800..0xDBFF: top six bits of the unit
    localparam logic [5:0] HIGH_SURR_TOP = 6'b110110;

    // Results of one accepted unit, held while they drain to the output
    typedef struct packed {
        logic [2:0][7:0]  bytes;
        logic [2:0][15:0] index;
        logic [1:0]       n_bytes;
        logic             summ;
        logic [1:0]       status;
        logic [15:0]      copied;
        logic [15:0]      consumed;
    } run_t;

endpackage

`default_nettype wire

@@ design/utf16le_to_utf8_budgeted_transcoder_top.sv @@
// Top level of the UTF-16LE to UTF-8 transcoder with a destination byte budget.
`default_nettype none

// Converts one UTF-16 code unit per input transfer into its UTF-8 bytes (one
// result per byte), followed by a summary result on a final unit. The
// conversion state is updated as a unit is accepted and its results are held
// in one output register that drains one result per cycle while out_ready is
// high. A unit has 0 to 3 bytes plus an optional summary, at most 4 results,
// and a unit with no result leaves the register empty. The next unit is
// accepted in the cycle the last result of the previous one is transferred.
module utf16le_to_utf8_budgeted_transcoder_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [15:0] src_unit,
    input  wire logic        first_unit,
    input  wire logic [15:0] budget,
    input  wire logic [15:0] dest_start,
    input  wire logic        final_unit,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             kind,
    output logic [7:0]       data_byte,
    output logic [15:0]      byte_index,
    output logic [1:0]       stop_status,
    output logic [15:0]      bytes_copied,
    output logic [15:0]      units_consumed,
    output logic             last_of_run
);

    localparam int CW = u16u8_pkg::COUNT_WIDTH;

    // Conversion state
    logic [15:0]   budget_left_reg, budget_left_next;
    logic          stopped_reg, stopped_next;
    logic [1:0]    stop_code_reg, stop_code_next;
    logic [CW-1:0] unit_count_reg, unit_count_next;
    logic [CW-1:0] byte_count_reg, byte_count_next;
    logic [15:0]   start_reg, start_next;

    // Output holding register
    logic            run_valid_reg, run_valid_next;
    logic [1:0]      ptr_reg, ptr_next;
    u16u8_pkg::run_t run_reg, run_next;

    logic in_xfer, out_xfer, at_byte;
    logic high_sur, fits;
    logic [1:0] need;
    logic [15:0] base_index;
    logic [15:0] bl_eff;
    logic        stopped_eff;
    logic [1:0]  code_eff;
    logic [CW-1:0] units_eff, bytes_eff;

    assign in_xfer  = in_valid && in_ready;
    assign out_xfer = out_valid && out_ready;
    assign in_ready = !run_valid_reg || (out_ready && last_of_run);

    // Drive the current result from the holding register
    assign at_byte = (ptr_reg < run_reg.n_bytes);
    always_comb
    begin
        out_valid      = run_valid_reg;
        kind           = at_byte ? u16u8_pkg::KIND_BYTE : u16u8_pkg::KIND_SUMMARY;
        data_byte      = 8'd0;
        byte_index     = 16'd0;
        stop_status    = u16u8_pkg::STOP_NONE;
        bytes_copied   = 16'd0;
        units_consumed = 16'd0;
        if (at_byte)
        begin
            case (ptr_reg)
                2'd0:
                begin
                    data_byte  = run_reg.bytes[0];
                    byte_index = run_reg.index[0];
                end
                2'd1:
                begin
                    data_byte  = run_reg.bytes[1];
                    byte_index = run_reg.index[1];
                end
                default:
                begin
                    data_byte  = run_reg.bytes[2];
                    byte_index = run_reg.index[2];
                end
            endcase
            last_of_run = (ptr_reg == run_reg.n_bytes - 2'd1) && !run_reg.summ;
        end
        else
        begin
            stop_status    = run_reg.status;
            bytes_copied   = run_reg.copied;
            units_consumed = run_reg.consumed;
            last_of_run    = 1'b1;
        end
    end

    // Take the state a first unit loads
    always_comb
    begin
        bl_eff      = first_unit ? budget : budget_left_reg;
        start_next  = first_unit ? dest_start : start_reg;
        stopped_eff = first_unit ? 1'b0 : stopped_reg;
        code_eff    = first_unit ? u16u8_pkg::STOP_NONE : stop_code_reg;
        units_eff   = first_unit ? '0 : unit_count_reg;
        bytes_eff   = first_unit ? '0 : byte_count_reg;
    end

    // Classify the unit and check it against the budget
    assign high_sur = (src_unit[15:10] == u16u8_pkg::HIGH_SURR_TOP);
    always_comb
    begin
        if (src_unit[15:7] == 9'd0)
            need = 2'd1;
        else if (src_unit[15:11] == 5'd0)
            need = 2'd2;
        else
            need = 2'd3;
    end
    assign fits       = ({14'd0, need} <= bl_eff);
    assign base_index = start_next + 16'(bytes_eff);

    // Update the conversion and build the results of the unit
    always_comb
    begin
        budget_left_next = bl_eff;
        stopped_next     = stopped_eff;
        stop_code_next   = code_eff;
        unit_count_next  = units_eff;
        byte_count_next  = bytes_eff;
        run_next.n_bytes = 2'd0;
        run_next.bytes[0] = src_unit[7:0];
        run_next.bytes[1] = {u16u8_pkg::CONT_PREFIX, src_unit[5:0]};
        run_next.bytes[2] = {u16u8_pkg::CONT_PREFIX, src_unit[5:0]};
        if (need == 2'd2)
            run_next.bytes[0] = {u16u8_pkg::LEAD2_PREFIX, src_unit[10:6]};
        else if (need == 2'd3)
        begin
            run_next.bytes[0] = {u16u8_pkg::LEAD3_PREFIX, src_unit[15:12]};
            run_next.bytes[1] = {u16u8_pkg::CONT_PREFIX, src_unit[11:6]};
        end
        run_next.index[0] = base_index;
        run_next.index[1] = base_index + 16'd1;
        run_next.index[2] = base_index + 16'd2;
        if (!stopped_eff)
        begin
            if (high_sur)
            begin
                stopped_next   = 1'b1;
                stop_code_next = u16u8_pkg::STOP_SURR;
            end
            else if (!fits)
            begin
                stopped_next   = 1'b1;
                stop_code_next = u16u8_pkg::STOP_FULL;
            end
            else
            begin
                run_next.n_bytes = need;
                budget_left_next = bl_eff - {14'd0, need};
                unit_count_next  = units_eff + CW'(1);
                byte_count_next  = bytes_eff + CW'(need);
            end
        end
        run_next.summ     = final_unit;
        run_next.status   = stop_code_next;
        run_next.copied   = 16'(byte_count_next);
        run_next.consumed = 16'(unit_count_next);
    end

    // Advance the output pointer or load a new run
    always_comb
    begin
        run_valid_next = run_valid_reg;
        ptr_next       = ptr_reg;
        if (out_xfer)
        begin
            if (last_of_run)
                run_valid_next = 1'b0;
            else
                ptr_next = ptr_reg + 2'd1;
        end
        if (in_xfer)
        begin
            run_valid_next = (run_next.n_bytes != 2'd0) || run_next.summ;
            ptr_next       = 2'd0;
        end
    end

    // Hold control and conversion state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_valid_reg   <= 1'b0;
            ptr_reg         <= 2'd0;
            budget_left_reg <= 16'd0;
            stopped_reg     <= 1'b0;
            stop_code_reg   <= u16u8_pkg::STOP_NONE;
            unit_count_reg  <= '0;
            byte_count_reg  <= '0;
            start_reg       <= 16'd0;
        end
        else
        begin
            run_valid_reg <= run_valid_next;
            ptr_reg       <= ptr_next;
            if (in_xfer)
            begin
                budget_left_reg <= budget_left_next;
                stopped_reg     <= stopped_next;
                stop_code_reg   <= stop_code_next;
                unit_count_reg  <= unit_count_next;
                byte_count_reg  <= byte_count_next;
                start_reg       <= start_next;
            end
        end
    end

    // Hold the result payload
    always_ff @(posedge clk)
    begin
        if (in_xfer)
            run_reg <= run_next;
    end

    // A held result always has something to show
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (run_reg.n_bytes != 2'd0 || run_reg.summ))
        else $error("held result is empty");

    // A new unit enters only as the last pending result leaves
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && out_valid) |-> (out_ready && last_of_run))
        else $error("unit accepted over pending results");

    // A summary always closes its run
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind == u16u8_pkg::KIND_SUMMARY) |-> last_of_run)
        else $error("summary not last of run");

    // A stopped conversion writes no more bytes until restarted
    assert property (@(posedge clk) disable iff (!rst_n)
        (stopped_reg && !(in_xfer && first_unit)) |=> $stable(byte_count_reg))
        else $error("byte count moved after stop");

endmodule

`default_nettype wire

@@ dv/u16u8_checker.sv @@
// Checker for the UTF-16LE to UTF-8 transcoder: predicts each transfer's bytes and summary.
`timescale 1ns / 100ps

module u16u8_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_ready,
    input  wire logic [15:0] src_unit,
    input  wire logic        first_unit,
    input  wire logic [15:0] budget,
    input  wire logic [15:0] dest_start,
    input  wire logic        final_unit,
    input  wire logic        out_valid,
    input  wire logic        out_ready,
    input  wire logic        kind,
    input  wire logic [7:0]  data_byte,
    input  wire logic [15:0] byte_index,
    input  wire logic [1:0]  stop_status,
    input  wire logic [15:0] bytes_copied,
    input  wire logic [15:0] units_consumed,
    input  wire logic        last_of_run,
    output int               mismatches,
    output int               pending,
    output int               units_seen,
    output int               bytes_seen,
    output int               summaries_seen,
    output int               full_stops,
    output int               surr_stops
);

    localparam logic [15:0] ONE_BYTE_LIMIT = 16'h0080;
    localparam logic [15:0] TWO_BYTE_LIMIT = 16'h0800;

    typedef struct packed {
        logic        kind;
        logic [7:0]  data_byte;
        logic [15:0] byte_index;
        logic [1:0]  stop_status;
        logic [15:0] bytes_copied;
        logic [15:0] units_consumed;
        logic        last_of_run;
    } utf8_result_t;

    // Shadow of the conversion state
    logic [15:0]                       budget_left;
    logic                              halted;
    logic [1:0]                        halt_code;
    logic [u16u8_pkg::COUNT_WIDTH-1:0] units_done;
    logic [u16u8_pkg::COUNT_WIDTH-1:0] bytes_done;
    logic [15:0]                       dest_base;

    utf8_result_t expected_q[$];
    utf8_result_t want;

    // Encode one accepted unit and queue the results it should cause
    task automatic predict_unit(input logic [15:0] cu, input logic first, input logic [15:0] bud,
                                input logic [15:0] dst, input logic fin);
        logic [7:0]   enc [3];
        int           nb;
        int           k;
        utf8_result_t r;
        nb = 0;
        if (first)
        begin
            budget_left = bud;
            dest_base   = dst;
            halted      = 1'b0;
            halt_code   = u16u8_pkg::STOP_NONE;
            units_done  = '0;
            bytes_done  = '0;
        end
        if (!halted)
        begin
            if (cu[15:10] == u16u8_pkg::HIGH_SURR_TOP)
            begin
                halted    = 1'b1;
                halt_code = u16u8_pkg::STOP_SURR;
            end
            else
            begin
                if (cu < ONE_BYTE_LIMIT)
                begin
                    nb     = 1;
                    enc[0] = cu[7:0];
                end
                else if (cu < TWO_BYTE_LIMIT)
                begin
                    nb     = 2;
                    enc[0] = {u16u8_pkg::LEAD2_PREFIX, cu[10:6]};
                    enc[1] = {u16u8_pkg::CONT_PREFIX, cu[5:0]};
                end
                else
                begin
                    nb     = 3;
                    enc[0] = {u16u8_pkg::LEAD3_PREFIX, cu[15:12]};
                    enc[1] = {u16u8_pkg::CONT_PREFIX, cu[11:6]};
                    enc[2] = {u16u8_pkg::CONT_PREFIX, cu[5:0]};
                end
                // Drop the whole unit when it does not fit the budget
                if (16'(nb) > budget_left)
                begin
                    nb        = 0;
                    halted    = 1'b1;
                    halt_code = u16u8_pkg::STOP_FULL;
                end
                else
                begin
                    budget_left = budget_left - 16'(nb);
                    units_done  = units_done + u16u8_pkg::COUNT_WIDTH'(1);
                end
            end
        end
        for (k = 0; k < nb; k++)
        begin
            r             = '0;
            r.kind        = u16u8_pkg::KIND_BYTE;
            r.data_byte   = enc[k];
            r.byte_index  = dest_base + 16'(bytes_done);
            r.last_of_run = (k == nb - 1) && !fin;
            expected_q.push_back(r);
            bytes_done = bytes_done + u16u8_pkg::COUNT_WIDTH'(1);
        end
        if (fin)
        begin
            r                = '0;
            r.kind           = u16u8_pkg::KIND_SUMMARY;
            r.stop_status    = halt_code;
            r.bytes_copied   = 16'(bytes_done);
            r.units_consumed = 16'(units_done);
            r.last_of_run    = 1'b1;
            expected_q.push_back(r);
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] exp_val,
                               input logic [15:0] act_val);
        if (exp_val !== act_val)
        begin
            mismatches++;
            $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h",
                     $time, name, exp_val, act_val);
        end
    endtask

    // Compare results before queuing new ones: both may transfer at the same edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            budget_left = '0;
            halted      = 1'b0;
            halt_code   = u16u8_pkg::STOP_NONE;
            units_done  = '0;
            bytes_done  = '0;
            dest_base   = '0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_q.size() == 0)
                begin
                    mismatches++;
                    $display("%0t ns: unexpected result, expected none, %s %0d byte 0x%0h index 0x%0h",
                             $time, "got kind", kind, data_byte, byte_index);
                end
                else
                begin
                    want = expected_q.pop_front();
                    check_field("kind", 16'(want.kind), 16'(kind));
                    check_field("data_byte", 16'(want.data_byte), 16'(data_byte));
                    check_field("byte_index", want.byte_index, byte_index);
                    check_field("stop_status", 16'(want.stop_status), 16'(stop_status));
                    check_field("bytes_copied", want.bytes_copied, bytes_copied);
                    check_field("units_consumed", want.units_consumed, units_consumed);
                    check_field("last_of_run", 16'(want.last_of_run), 16'(last_of_run));
                end
                if (kind == u16u8_pkg::KIND_SUMMARY)
                begin
                    summaries_seen++;
                    if (stop_status == u16u8_pkg::STOP_FULL)
                        full_stops++;
                    if (stop_status == u16u8_pkg::STOP_SURR)
                        surr_stops++;
                end
                else
                begin
                    bytes_seen++;
                end
            end
            if (in_valid && in_ready)
            begin
                units_seen++;
                predict_unit(src_unit, first_unit, budget, dest_start, final_unit);
            end
            pending = expected_q.size();
        end
    end

endmodule

@@ dv/tb_top.sv @@
// Testbench top for the UTF-16LE to UTF-8 transcoder: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_top;

    localparam int QUIET_LIMIT   = 2000;
    localparam int DRAIN_CYCLES  = 16;
    localparam int PHASE_UNITS   = 125;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [15:0] src_unit;
    logic        first_unit;
    logic [15:0] budget;
    logic [15:0] dest_start;
    logic        final_unit;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        kind;
    logic [7:0]  data_byte;
    logic [15:0] byte_index;
    logic [1:0]  stop_status;
    logic [15:0] bytes_copied;
    logic [15:0] units_consumed;
    logic        last_of_run;

    int mismatches;
    int pending;
    int units_seen;
    int bytes_seen;
    int summaries_seen;
    int full_stops;
    int surr_stops;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int quiet_cycles   = 0;

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    utf16le_to_utf8_budgeted_transcoder_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .src_unit       (src_unit),
        .first_unit     (first_unit),
        .budget         (budget),
        .dest_start     (dest_start),
        .final_unit     (final_unit),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .kind           (kind),
        .data_byte      (data_byte),
        .byte_index     (byte_index),
        .stop_status    (stop_status),
        .bytes_copied   (bytes_copied),
        .units_consumed (units_consumed),
        .last_of_run    (last_of_run)
    );

    u16u8_checker scoreboard (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .src_unit       (src_unit),
        .first_unit     (first_unit),
        .budget         (budget),
        .dest_start     (dest_start),
        .final_unit     (final_unit),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .kind           (kind),
        .data_byte      (data_byte),
        .byte_index     (byte_index),
        .stop_status    (stop_status),
        .bytes_copied   (bytes_copied),
        .units_consumed (units_consumed),
        .last_of_run    (last_of_run),
        .mismatches     (mismatches),
        .pending        (pending),
        .units_seen     (units_seen),
        .bytes_seen     (bytes_seen),
        .summaries_seen (summaries_seen),
        .full_stops     (full_stops),
        .surr_stops     (surr_stops)
    );

    // Stall the result channel at the current phase's rate
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // End the run when no transfer happens for too long
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // Present one code unit and hold it until the transfer
    task automatic send_unit(input logic [15:0] cu, input logic first, input logic [15:0] bud,
                             input logic [15:0] dst, input logic fin);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        src_unit   <= cu;
        first_unit <= first;
        budget     <= bud;
        dest_start <= dst;
        final_unit <= fin;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    initial
    begin
        logic [15:0] cu;
        logic [15:0] bud;
        logic [15:0] dst;
        int          phase;
        int          sent;
        int          conv_len;
        int          k;
        int          cls;
        logic        noisy;
        logic        ends;

        rst_n      = 1'b0;
        in_valid   = 1'b0;
        src_unit   = '0;
        first_unit = 1'b0;
        budget     = '0;
        dest_start = '0;
        final_unit = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Unit straight after reset: zero budget, so it stops as destination full
        send_unit(16'h0041, 1'b0, 16'h1234, 16'h5678, 1'b1);
        // Boundaries of every byte length, low surrogates, index wrap
        send_unit(16'h0000, 1'b1, 16'hFFFF, 16'hFFFE, 1'b0);
        send_unit(16'h007F, 1'b0, 16'h0000, 16'h0000, 1'b0);
        send_unit(16'h0080, 1'b0, 16'h0000, 16'h0000, 1'b0);
        send_unit(16'h07FF, 1'b0, 16'h0000, 16'h0000, 1'b0);
        send_unit(16'h0800, 1'b0, 16'h0000, 16'h0000, 1'b0);
        send_unit(16'hD7FF, 1'b0, 16'h0000, 16'h0000, 1'b0);
        send_unit(16'hDC00, 1'b0, 16'h0000, 16'h0000, 1'b0);
        send_unit(16'hDFFF, 1'b0, 16'h0000, 16'h0000, 1'b0);
        send_unit(16'hE000, 1'b0, 16'h0000, 16'h0000, 1'b0);
        send_unit(16'hFFFF, 1'b0, 16'hFFFF, 16'hFFFF, 1'b1);
        // Continue the ended conversion without a new start
        send_unit(16'h0042, 1'b0, 16'h0000, 16'h0000, 1'b1);
        // Budget runs out mid-stream; later units are ignored
        send_unit(16'h0041, 1'b1, 16'd2, 16'h0010, 1'b0);
        send_unit(16'h0100, 1'b0, 16'h0000, 16'h0000, 1'b0);
        send_unit(16'h0042, 1'b0, 16'h0000, 16'h0000, 1'b0);
        send_unit(16'h0043, 1'b0, 16'h0000, 16'h0000, 1'b1);
        // Exact fit of a three-byte unit
        send_unit(16'h0800, 1'b1, 16'd3, 16'h0000, 1'b1);
        // High surrogates stop the conversion
        send_unit(16'hD800, 1'b1, 16'd10, 16'h0100, 1'b0);
        send_unit(16'h0041, 1'b0, 16'h0000, 16'h0000, 1'b1);
        send_unit(16'hDBFF, 1'b1, 16'hFFFF, 16'hFFFF, 1'b1);
        // Stopped, not final: no result at all
        send_unit(16'h0044, 1'b0, 16'h0000, 16'h0000, 1'b0);
        // Zero budget on a fresh start
        send_unit(16'h0000, 1'b1, 16'h0000, 16'h0000, 1'b1);

        // Random conversions under four pacing phases
        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
                default: begin send_idle_pct = 23; recv_stall_pct = 23; end
            endcase
            sent = 0;
            while (sent < PHASE_UNITS)
            begin
                conv_len = $urandom_range(1, 8);
                noisy    = ($urandom_range(0, 9) == 0);
                ends     = ($urandom_range(0, 9) != 0);
                case ($urandom_range(0, 9))
                    0: bud = 16'($urandom);
                    1: bud = 16'hFFFF;
                    default: bud = 16'($urandom_range(0, 14));
                endcase
                if ($urandom_range(0, 3) == 0)
                    dst = 16'hFFFF - 16'($urandom_range(0, 6));
                else
                    dst = 16'($urandom);
                for (k = 0; k < conv_len; k++)
                begin
                    cls = $urandom_range(0, 99);
                    if (cls < 35)
                        cu = 16'($urandom_range(16'h0000, 16'h007F));
                    else if (cls < 55)
                        cu = 16'($urandom_range(16'h0080, 16'h07FF));
                    else if (cls < 70)
                        cu = 16'($urandom_range(16'h0800, 16'hD7FF));
                    else if (cls < 78)
                        cu = 16'($urandom_range(16'hDC00, 16'hDFFF));
                    else if (cls < 88)
                        cu = 16'($urandom_range(16'hE000, 16'hFFFF));
                    else if (cls < 92)
                        cu = 16'($urandom_range(16'hD800, 16'hDBFF));
                    else
                        cu = 16'($urandom);
                    if (noisy)
                        send_unit(cu, 1'($urandom), 16'($urandom), 16'($urandom), 1'($urandom));
                    else if (k == 0)
                        send_unit(cu, 1'b1, bud, dst, ends && (conv_len == 1));
                    else
                        send_unit(cu, 1'b0, 16'($urandom), 16'($urandom),
                                  ends && (k == conv_len - 1));
                    sent++;
                end
            end
        end
        in_valid <= 1'b0;
        @(posedge clk);

        // Drain, then give late results a chance to show up
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d code units, %0d UTF-8 bytes and %0d conversion summaries",
                 units_seen, bytes_seen, summaries_seen);
        $display("Summaries with budget stop: %0d, with high surrogate stop: %0d",
                 full_stops, surr_stops);
        if (mismatches == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
